### design/ckl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckl_pkg - shared types and constants of the keypad code lock
// Field widths, key and event codes, and the state and config records.
// ----------------------------------------------------------------------------
package ckl_pkg;

  // Code geometry
  localparam int CODE_DIGITS = 4;
  localparam int ENTRY_LEN   = 2 * CODE_DIGITS;
  localparam int CNT_W       = $clog2(ENTRY_LEN + 1);
  localparam int IDX_W       = $clog2(ENTRY_LEN);

  // Field widths
  localparam int KEY_W   = 4;
  localparam int DIGIT_W = 4;
  localparam int LAMP_W  = 4;
  localparam int VIEW_W  = 3;
  localparam int EVT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int TMR_W   = 16;
  localparam int TRY_W   = 3;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RELOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIES  = 2'd3;

  // Configuration reset values
  localparam logic [TMR_W-1:0] RELOCK_RST = 16'd2000;
  localparam logic [TMR_W-1:0] ALARM_RST  = 16'd9000;
  localparam logic [TMR_W-1:0] WINDOW_RST = 16'd20000;
  localparam logic [TRY_W-1:0] TRIES_RST  = 3'd5;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [KEY_W-1:0] KEY_VIEW_FIRST = 4'd10;
  localparam logic [KEY_W-1:0] KEY_VIEW_LAST  = 4'd12;
  localparam logic [KEY_W-1:0] KEY_ENTER      = 4'd13;
  localparam logic [KEY_W-1:0] KEY_CHANGE     = 4'd14;
  localparam logic [KEY_W-1:0] KEY_CLEAR      = 4'd15;

  // Item kinds
  localparam logic MODE_TICK = 1'b0;

  // Views
  localparam logic [VIEW_W-1:0] VIEW_TIME   = 3'd0;
  localparam logic [VIEW_W-1:0] VIEW_ENTRY  = 3'd3;
  localparam logic [VIEW_W-1:0] VIEW_CHANGE = 3'd4;

  // Lock status
  localparam logic [STAT_W-1:0] ST_CLOSED = 2'd0;
  localparam logic [STAT_W-1:0] ST_OPEN   = 2'd1;
  localparam logic [STAT_W-1:0] ST_LOCKED = 2'd2;

  // Events
  localparam logic [EVT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVT_W-1:0] EV_WRONG    = 3'd1;
  localparam logic [EVT_W-1:0] EV_ALARM    = 3'd2;
  localparam logic [EVT_W-1:0] EV_REJECTED = 3'd3;
  localparam logic [EVT_W-1:0] EV_LOCKOUT  = 3'd4;

  // Lamp patterns
  localparam logic [LAMP_W-1:0] LAMP_OFF    = 4'd0;
  localparam logic [LAMP_W-1:0] LAMP_WRONG  = 4'd1;
  localparam logic [LAMP_W-1:0] LAMP_ALARM  = 4'd2;
  localparam logic [LAMP_W-1:0] LAMP_REJECT = 4'd4;
  localparam logic [LAMP_W-1:0] LAMP_ALL    = 4'd15;

  localparam logic [TMR_W-1:0] TMR_MAX  = '1;
  localparam logic [TRY_W-1:0] FAIL_MAX = '1;

  typedef struct packed {
    logic [TMR_W-1:0] relock_delay_ms;
    logic [TMR_W-1:0] alarm_delay_ms;
    logic [TMR_W-1:0] try_window_ms;
    logic [TRY_W-1:0] max_tries;
  } ckl_cfg_t;

  typedef struct packed {
    logic [CODE_DIGITS-1:0][DIGIT_W-1:0] stored_code;
    logic [ENTRY_LEN-1:0][DIGIT_W-1:0]   entry_digits;
    logic [CNT_W-1:0]                    entry_count;
    logic [VIEW_W-1:0]                   view_mode;
    logic                                open_flag;
    logic [TMR_W-1:0]                    open_timer;
    logic [TRY_W-1:0]                    fail_count;
    logic [TMR_W-1:0]                    fail_timer;
    logic                                locked_out;
    logic [STAT_W-1:0]                   status_code;
    logic [LAMP_W-1:0]                   lamp_reg;
  } ckl_state_t;

  // State after reset: stored code counts 1,2,3,...
  function automatic ckl_state_t state_reset();
    ckl_state_t s;
    s = '0;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      s.stored_code[i] = DIGIT_W'(i + 1);
    end
    return s;
  endfunction

endpackage

### design/ckl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckl_if - channel interfaces of the keypad code lock
// Input channel carries ticks and key presses, output channel the status.
// ----------------------------------------------------------------------------
interface ckl_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [ckl_pkg::KEY_W-1:0] key;

  modport source (output valid, mode, key, input ready);
  modport sink   (input valid, mode, key, output ready);
endinterface

interface ckl_out_if;
  logic                       valid;
  logic                       ready;
  logic [ckl_pkg::LAMP_W-1:0] lamps;
  logic                       door_open;
  logic [ckl_pkg::STAT_W-1:0] lock_state;
  logic [ckl_pkg::EVT_W-1:0]  event_res;
  logic [ckl_pkg::VIEW_W-1:0] view;
  logic [ckl_pkg::CNT_W-1:0]  entered;

  modport source (output valid, lamps, door_open, lock_state, event_res, view, entered,
                  input ready);
  modport sink   (input valid, lamps, door_open, lock_state, event_res, view, entered,
                  output ready);
endinterface

### design/ckl_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckl_cfg_regs - configuration register bank
// Holds the relock, alarm and try-window delays and the try limit.
// ----------------------------------------------------------------------------
module ckl_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ckl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ckl_pkg::CFG_W-1:0]     cfg_data,
  output ckl_pkg::ckl_cfg_t             cfg
);

  // Register writes, decoded by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.relock_delay_ms <= ckl_pkg::RELOCK_RST;
      cfg.alarm_delay_ms  <= ckl_pkg::ALARM_RST;
      cfg.try_window_ms   <= ckl_pkg::WINDOW_RST;
      cfg.max_tries       <= ckl_pkg::TRIES_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        ckl_pkg::REG_RELOCK: cfg.relock_delay_ms <= cfg_data;
        ckl_pkg::REG_ALARM:  cfg.alarm_delay_ms  <= cfg_data;
        ckl_pkg::REG_WINDOW: cfg.try_window_ms   <= cfg_data;
        ckl_pkg::REG_TRIES:  cfg.max_tries       <= cfg_data[ckl_pkg::TRY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### design/ckl_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckl_step - next-state logic of the keypad code lock
// Applies one tick or key press to the lock state and names the event.
// ----------------------------------------------------------------------------
module ckl_step (
  input  ckl_pkg::ckl_state_t           state,
  input  ckl_pkg::ckl_cfg_t             cfg,
  input  logic                          mode,
  input  logic [ckl_pkg::KEY_W-1:0]     key,
  output ckl_pkg::ckl_state_t           state_next,
  output logic [ckl_pkg::EVT_W-1:0]     event_res
);

  localparam logic [ckl_pkg::CNT_W-1:0] CNT_CODE  = ckl_pkg::CNT_W'(ckl_pkg::CODE_DIGITS);
  localparam logic [ckl_pkg::CNT_W-1:0] CNT_ENTRY = ckl_pkg::CNT_W'(ckl_pkg::ENTRY_LEN);

  // Entered old code against the stored one
  logic code_match;
  always_comb begin
    code_match = 1'b1;
    for (int i = 0; i < ckl_pkg::CODE_DIGITS; i++) begin
      if (state.stored_code[i] != state.entry_digits[i]) code_match = 1'b0;
    end
  end

  // New code occupies the upper half of the entry buffer
  logic fresh_zero;
  always_comb begin
    fresh_zero = 1'b1;
    for (int i = 0; i < ckl_pkg::CODE_DIGITS; i++) begin
      if (state.entry_digits[ckl_pkg::CODE_DIGITS + i] != '0) fresh_zero = 1'b0;
    end
  end

  // Step logic
  always_comb begin
    ckl_pkg::ckl_state_t s;
    logic                fail;
    logic [ckl_pkg::TRY_W-1:0] fails;
    logic [ckl_pkg::IDX_W-1:0] idx;

    s     = state;
    fail  = 1'b0;
    fails = '0;
    idx   = '0;
    event_res = ckl_pkg::EV_NONE;

    if (!state.locked_out) begin
      if (mode == ckl_pkg::MODE_TICK) begin
        // Open timer
        if (s.open_flag) begin
          if (s.open_timer != ckl_pkg::TMR_MAX) s.open_timer = s.open_timer + 1'b1;
        end else begin
          s.open_timer = '0;
        end
        if (s.open_flag && s.open_timer >= cfg.relock_delay_ms) begin
          s.lamp_reg     = ckl_pkg::LAMP_OFF;
          s.entry_digits = '0;
          s.entry_count  = '0;
        end
        if (s.open_flag && s.open_timer >= cfg.alarm_delay_ms) begin
          s.lamp_reg = ckl_pkg::LAMP_ALARM;
          event_res  = ckl_pkg::EV_ALARM;
        end
        // Try window
        if (s.fail_count != '0 && s.fail_count < cfg.max_tries &&
            s.fail_timer != ckl_pkg::TMR_MAX) begin
          s.fail_timer = s.fail_timer + 1'b1;
        end
        if (s.fail_timer >= cfg.try_window_ms) begin
          s.fail_count = '0;
          s.fail_timer = '0;
        end
      end else begin
        // View selection
        if (key >= ckl_pkg::KEY_VIEW_FIRST && key <= ckl_pkg::KEY_VIEW_LAST) begin
          s.view_mode = ckl_pkg::VIEW_W'(key - ckl_pkg::KEY_VIEW_FIRST);
        end
        if (key == ckl_pkg::KEY_ENTER && s.view_mode != ckl_pkg::VIEW_ENTRY) begin
          s.view_mode   = ckl_pkg::VIEW_ENTRY;
          s.entry_count = '0;
        end
        if (key == ckl_pkg::KEY_CHANGE &&
            ((s.view_mode != ckl_pkg::VIEW_CHANGE && s.view_mode != ckl_pkg::VIEW_ENTRY) ||
             (s.view_mode == ckl_pkg::VIEW_ENTRY && s.entry_count == '0))) begin
          s.view_mode   = ckl_pkg::VIEW_CHANGE;
          s.entry_count = '0;
        end
        // Digit entry
        idx = s.entry_count[ckl_pkg::IDX_W-1:0];
        if (key <= ckl_pkg::KEY_LAST_DIGIT) begin
          if ((s.view_mode == ckl_pkg::VIEW_ENTRY && s.entry_count < CNT_CODE) ||
              (s.view_mode == ckl_pkg::VIEW_CHANGE && s.entry_count < CNT_ENTRY)) begin
            s.entry_digits[idx] = key;
            s.entry_count       = s.entry_count + 1'b1;
          end
        end
        // Unlock
        if (key == ckl_pkg::KEY_ENTER && s.view_mode == ckl_pkg::VIEW_ENTRY &&
            s.entry_count == CNT_CODE) begin
          if (code_match) begin
            s.lamp_reg    = ckl_pkg::LAMP_ALL;
            s.open_flag   = 1'b1;
            s.status_code = ckl_pkg::ST_OPEN;
            s.fail_count  = '0;
          end else begin
            fail = 1'b1;
          end
        end
        // Code change: old code check, then the new code
        if (key == ckl_pkg::KEY_CHANGE && s.view_mode == ckl_pkg::VIEW_CHANGE &&
            s.entry_count == CNT_ENTRY) begin
          if (code_match) begin
            s.fail_count   = '0;
            s.entry_digits = '0;
            s.entry_count  = '0;
            if (fresh_zero) begin
              s.lamp_reg = ckl_pkg::LAMP_REJECT;
              event_res  = ckl_pkg::EV_REJECTED;
            end else begin
              s.lamp_reg    = ckl_pkg::LAMP_ALL;
              for (int i = 0; i < ckl_pkg::CODE_DIGITS; i++) begin
                s.stored_code[i] = state.entry_digits[ckl_pkg::CODE_DIGITS + i];
              end
              s.view_mode   = ckl_pkg::VIEW_ENTRY;
              s.status_code = ckl_pkg::ST_CLOSED;
            end
          end else begin
            fail = 1'b1;
          end
        end
        // Backspace, or close when nothing to remove
        if (key == ckl_pkg::KEY_CLEAR) begin
          if ((s.view_mode == ckl_pkg::VIEW_ENTRY || s.view_mode == ckl_pkg::VIEW_CHANGE) &&
              s.entry_count != '0 && s.entry_count <= CNT_ENTRY) begin
            s.entry_count       = s.entry_count - 1'b1;
            s.entry_digits[s.entry_count[ckl_pkg::IDX_W-1:0]] = '0;
          end else begin
            s.open_flag    = 1'b0;
            s.lamp_reg     = ckl_pkg::LAMP_OFF;
            s.entry_digits = '0;
            s.entry_count  = '0;
            s.view_mode    = ckl_pkg::VIEW_TIME;
            s.status_code  = ckl_pkg::ST_CLOSED;
          end
        end
        // Failed try: count it, lock out at the limit
        if (fail) begin
          fails      = (s.fail_count != ckl_pkg::FAIL_MAX) ? s.fail_count + 1'b1 : s.fail_count;
          s.lamp_reg   = ckl_pkg::LAMP_WRONG;
          s.fail_count = fails;
          if (fails >= cfg.max_tries) begin
            s.locked_out  = 1'b1;
            s.status_code = ckl_pkg::ST_LOCKED;
            event_res     = ckl_pkg::EV_LOCKOUT;
          end else begin
            s.entry_count = '0;
            event_res     = ckl_pkg::EV_WRONG;
          end
        end
      end
    end

    state_next = s;
  end

endmodule

### design/keypad_code_lock_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_controller - four-digit keypad lock controller
// Takes ticks and key presses, returns one status transaction for each.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per event; mode 0 is a 1 ms tick, mode 1 a key
//            press with the key code in key.
//   out_ch : exactly one transaction per input transaction, in order, with
//            lamps, door_open, lock_state, event_res, view and entered.
//   cfg_we/cfg_idx/cfg_data : write-only registers (0 relock delay,
//            1 alarm delay, 2 try window, 3 max tries); write while idle.
// Pipeline: an event accepted into the input register is stepped through the
//   lock logic, and its result is loaded into the result register when that
//   stage advances.
// Throughput: one event per cycle while out_ch is not stalled; the step logic
//   between the input register and the result register is a single pass.
// Reset: rst (synchronous) restores code 1,2,3,4, clears entry, timers, tries
//   and lockout, and loads the register defaults 2000, 9000, 20000 and 5.
// Stall: with out_ch.ready low the result holds; one more event may wait in
//   the input register, after which in_ch.ready drops.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller (
  input  logic                          clk,
  input  logic                          rst,
  ckl_in_if.sink                        in_ch,
  ckl_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [ckl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ckl_pkg::CFG_W-1:0]     cfg_data
);

  ckl_pkg::ckl_cfg_t   cfg;
  ckl_pkg::ckl_state_t state;
  ckl_pkg::ckl_state_t state_next;
  logic [ckl_pkg::EVT_W-1:0] event_next;

  logic                      in_vld;
  logic                      in_mode;
  logic [ckl_pkg::KEY_W-1:0] in_key;
  logic                      out_vld;
  logic                      advance;

  ckl_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  ckl_step u_step (
    .state      (state),
    .cfg        (cfg),
    .mode       (in_mode),
    .key        (in_key),
    .state_next (state_next),
    .event_res  (event_next)
  );

  // Handshake: the result stage moves when empty or taken
  assign advance      = !out_vld || out_ch.ready;
  assign in_ch.ready  = !in_vld || advance;
  assign out_ch.valid = out_vld;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_mode <= in_ch.mode;
      in_key  <= in_ch.key;
    end
  end

  // Lock state, committed as each event moves to the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ckl_pkg::state_reset();
    end else if (in_vld && advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && advance) begin
      out_ch.lamps      <= state_next.lamp_reg;
      out_ch.door_open  <= state_next.open_flag;
      out_ch.lock_state <= state_next.status_code;
      out_ch.event_res  <= event_next;
      out_ch.view       <= state_next.view_mode;
      out_ch.entered    <= state_next.entry_count;
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the keypad code lock controller
// Feeds ticks and key presses, recomputes every status transaction in a
// scoreboard with its own lock model, and checks the results in order.
// Covers view switching, unlock, code change, backspace and close, the open
// and try timers under several delay settings, and a final lockout.
// ----------------------------------------------------------------------------
module tb_top;
  import ckl_pkg::*;

  localparam logic MODE_KEY = ~MODE_TICK;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLD_AT        = 500;
  localparam int unsigned HOLD_CYCLES    = 150;

  // Lock state as the scoreboard tracks it
  typedef struct {
    logic [DIGIT_W-1:0] code [CODE_DIGITS];
    logic [DIGIT_W-1:0] digits [ENTRY_LEN];
    logic [CNT_W-1:0]   count;
    logic [VIEW_W-1:0]  view;
    logic               is_open;
    logic [TMR_W-1:0]   open_tmr;
    logic [TRY_W-1:0]   fails;
    logic [TMR_W-1:0]   fail_tmr;
    logic               locked;
    logic [STAT_W-1:0]  status;
    logic [LAMP_W-1:0]  lamps;
  } lock_ctx_t;

  // One status transaction
  typedef struct packed {
    logic [LAMP_W-1:0] lamps;
    logic              door_open;
    logic [STAT_W-1:0] lock_state;
    logic [EVT_W-1:0]  event_res;
    logic [VIEW_W-1:0] view;
    logic [CNT_W-1:0]  entered;
  } status_t;

  // --------------------------------------------------------------------------
  // Scoreboard: lock model plus the queue of status transactions due
  // --------------------------------------------------------------------------
  class lock_scoreboard;
    logic [TMR_W-1:0] relock_ms, alarm_ms, window_ms;
    logic [TRY_W-1:0] tries;
    lock_ctx_t        st;
    status_t          pending_status [$];
    int unsigned      errors;

    function new();
      relock_ms = RELOCK_RST;
      alarm_ms  = ALARM_RST;
      window_ms = WINDOW_RST;
      tries     = TRIES_RST;
      for (int i = 0; i < CODE_DIGITS; i++) st.code[i] = DIGIT_W'(i + 1);
      for (int i = 0; i < ENTRY_LEN; i++) st.digits[i] = '0;
      st.count    = '0;
      st.view     = VIEW_TIME;
      st.is_open  = 1'b0;
      st.open_tmr = '0;
      st.fails    = '0;
      st.fail_tmr = '0;
      st.locked   = 1'b0;
      st.status   = ST_CLOSED;
      st.lamps    = LAMP_OFF;
      errors      = 0;
    endfunction

    function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_RELOCK: relock_ms = data;
        REG_ALARM:  alarm_ms  = data;
        REG_WINDOW: window_ms = data;
        REG_TRIES:  tries     = data[TRY_W-1:0];
        default: ;
      endcase
    endfunction

    function void wipe_entry(inout lock_ctx_t s);
      s.lamps = LAMP_OFF;
      for (int i = 0; i < ENTRY_LEN; i++) s.digits[i] = '0;
      s.count = '0;
    endfunction

    function bit code_ok(lock_ctx_t s);
      for (int i = 0; i < CODE_DIGITS; i++)
        if (s.code[i] != s.digits[i]) return 1'b0;
      return 1'b1;
    endfunction

    // Wrong code: lamp, try count, and lockout once the limit is hit
    function logic [EVT_W-1:0] count_failure(inout lock_ctx_t s);
      s.lamps = LAMP_WRONG;
      if (s.fails < FAIL_MAX) s.fails++;
      if (s.fails >= tries) begin
        s.locked = 1'b1;
        s.status = ST_LOCKED;
        return EV_LOCKOUT;
      end
      s.count = '0;
      return EV_WRONG;
    endfunction

    // One tick or key press applied to s; r is the status it reports
    function void step_lock(inout lock_ctx_t s, input logic m,
                            input logic [KEY_W-1:0] k, output status_t r);
      logic [EVT_W-1:0]   ev;
      logic               zero_code;
      logic [DIGIT_W-1:0] fresh [CODE_DIGITS];
      ev = EV_NONE;
      if (!s.locked) begin
        if (m == MODE_TICK) begin
          // open timer, relock, alarm
          if (s.is_open) begin
            if (s.open_tmr != TMR_MAX) s.open_tmr++;
          end else begin
            s.open_tmr = '0;
          end
          if (s.is_open && s.open_tmr >= relock_ms) wipe_entry(s);
          if (s.is_open && s.open_tmr >= alarm_ms) begin
            s.lamps = LAMP_ALARM;
            ev = EV_ALARM;
          end
          // try window
          if (s.fails != 0 && s.fails < tries && s.fail_tmr != TMR_MAX) s.fail_tmr++;
          if (s.fail_tmr >= window_ms) begin
            s.fails    = '0;
            s.fail_tmr = '0;
          end
        end else begin
          if (k >= KEY_VIEW_FIRST && k <= KEY_VIEW_LAST) s.view = VIEW_W'(k - KEY_VIEW_FIRST);
          if (k == KEY_ENTER && s.view != VIEW_ENTRY) begin
            s.view  = VIEW_ENTRY;
            s.count = '0;
          end
          if (k == KEY_CHANGE && ((s.view != VIEW_CHANGE && s.view != VIEW_ENTRY) ||
                                  (s.view == VIEW_ENTRY && s.count == 0))) begin
            s.view  = VIEW_CHANGE;
            s.count = '0;
          end
          if (k <= KEY_LAST_DIGIT) begin
            if ((s.view == VIEW_ENTRY && s.count < CODE_DIGITS) ||
                (s.view == VIEW_CHANGE && s.count < ENTRY_LEN)) begin
              s.digits[s.count] = k;
              s.count++;
            end
          end
          // unlock attempt
          if (k == KEY_ENTER && s.view == VIEW_ENTRY && s.count == CODE_DIGITS) begin
            if (code_ok(s)) begin
              s.lamps   = LAMP_ALL;
              s.is_open = 1'b1;
              s.status  = ST_OPEN;
              s.fails   = '0;
            end else begin
              ev = count_failure(s);
            end
          end
          // code change: old code, then new code; the new one is read before the wipe
          if (k == KEY_CHANGE && s.view == VIEW_CHANGE && s.count == ENTRY_LEN) begin
            if (code_ok(s)) begin
              zero_code = 1'b1;
              for (int i = 0; i < CODE_DIGITS; i++) begin
                fresh[i] = s.digits[CODE_DIGITS + i];
                if (fresh[i] != 0) zero_code = 1'b0;
              end
              s.fails = '0;
              wipe_entry(s);
              if (zero_code) begin
                s.lamps = LAMP_REJECT;
                ev = EV_REJECTED;
              end else begin
                s.lamps  = LAMP_ALL;
                s.code   = fresh;
                s.view   = VIEW_ENTRY;
                s.status = ST_CLOSED;
              end
            end else begin
              ev = count_failure(s);
            end
          end
          // backspace, or close when nothing to remove
          if (k == KEY_CLEAR) begin
            if ((s.view == VIEW_ENTRY || s.view == VIEW_CHANGE) && s.count > 0 &&
                s.count <= ENTRY_LEN) begin
              s.digits[s.count - 1] = '0;
              s.count--;
            end else begin
              s.is_open = 1'b0;
              wipe_entry(s);
              s.view   = VIEW_TIME;
              s.status = ST_CLOSED;
            end
          end
        end
      end
      r.lamps      = s.lamps;
      r.door_open  = s.is_open;
      r.lock_state = s.status;
      r.event_res  = ev;
      r.view       = s.view;
      r.entered    = s.count;
    endfunction

    function void note_event(logic m, logic [KEY_W-1:0] k);
      status_t r;
      step_lock(st, m, k, r);
      pending_status.push_back(r);
    endfunction

    // True when this item would lock the block out
    function bit would_lock(logic m, logic [KEY_W-1:0] k);
      lock_ctx_t probe;
      status_t   r;
      probe = st;
      step_lock(probe, m, k, r);
      return probe.locked && !st.locked;
    endfunction

    function int unsigned pending();
      return pending_status.size();
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (pending_status.size() == 0) begin
        $display("%0t: status transaction with none due, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_status.pop_front();
      if (got.lamps !== want.lamps)           report("lamps", want.lamps, got.lamps);
      if (got.door_open !== want.door_open)   report("door_open", want.door_open, got.door_open);
      if (got.lock_state !== want.lock_state) report("lock_state", want.lock_state, got.lock_state);
      if (got.event_res !== want.event_res)   report("event_res", want.event_res, got.event_res);
      if (got.view !== want.view)             report("view", want.view, got.view);
      if (got.entered !== want.entered)       report("entered", want.entered, got.entered);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT, shared state
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  ckl_in_if  in_ch();
  ckl_out_if out_ch();

  lock_scoreboard sb = new();
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  bit          no_gaps      = 1'b0;
  bit          guard_on     = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keypad_code_lock_controller uut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one item and wait for the transaction; a would-be lockout
  // becomes a tick while the guard is on
  task automatic offer(input logic m, input logic [KEY_W-1:0] k);
    int unsigned gap, roll;
    logic        mm;
    mm = m;
    if (guard_on && sb.would_lock(mm, k)) mm = MODE_TICK;
    gap = 0;
    if (!no_gaps) begin
      roll = $urandom_range(99);
      if (roll < 65)      gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else if (roll < 98) gap = $urandom_range(4, 10);
      else                gap = $urandom_range(20, 60);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mm;
    in_ch.key   <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_event(mm, k);
    items_sent++;
  endtask

  task automatic press(input logic [KEY_W-1:0] k);
    offer(MODE_KEY, k);
  endtask

  task automatic tick();
    offer(MODE_TICK, KEY_W'($urandom()));
  endtask

  // Drop valid and wait until every status transaction is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_cfg(idx, data);
  endtask

  task automatic write_settings(input logic [CFG_W-1:0] relock, input logic [CFG_W-1:0] alarm,
                                input logic [CFG_W-1:0] window, input logic [CFG_W-1:0] tries);
    put_reg(REG_RELOCK, relock);
    put_reg(REG_ALARM, alarm);
    put_reg(REG_WINDOW, window);
    put_reg(REG_TRIES, tries);
    cfg_we <= 1'b0;
  endtask

  // Leave the entry view so the next enter starts a fresh attempt
  task automatic leave_entry();
    press(KEY_VIEW_FIRST + KEY_W'($urandom_range(2)));
  endtask

  task automatic try_unlock();
    bit good;
    good = ($urandom_range(99) < 60);
    if (sb.st.view == VIEW_ENTRY) leave_entry();
    press(KEY_ENTER);
    for (int i = 0; i < CODE_DIGITS; i++)
      press(good ? KEY_W'(sb.st.code[i]) : KEY_W'($urandom_range(9)));
    press(KEY_ENTER);
  endtask

  task automatic change_code();
    bit good, zero_new;
    good     = ($urandom_range(99) < 70);
    zero_new = ($urandom_range(99) < 15);
    if (sb.st.view == VIEW_CHANGE || (sb.st.view == VIEW_ENTRY && sb.st.count != 0))
      leave_entry();
    press(KEY_CHANGE);
    for (int i = 0; i < CODE_DIGITS; i++)
      press(good ? KEY_W'(sb.st.code[i]) : KEY_W'($urandom_range(9)));
    for (int i = 0; i < CODE_DIGITS; i++)
      press(zero_new ? KEY_W'(0) : KEY_W'($urandom_range(9)));
    press(KEY_CHANGE);
  endtask

  // Digits then backspaces, running past the buffer now and then
  task automatic edit_entry();
    int unsigned n_dig, n_back;
    n_dig  = $urandom_range(1, 9);
    n_back = $urandom_range(1, 4);
    press(($urandom_range(1) == 0) ? KEY_ENTER : KEY_CHANGE);
    repeat (n_dig) press(KEY_W'($urandom_range(9)));
    repeat (n_back) press(KEY_CLEAR);
  endtask

  // Tick bursts, now and then long enough to reach one of the programmed delays
  task automatic tick_burst();
    int unsigned reach, n;
    case ($urandom_range(2))
      0:       reach = sb.relock_ms;
      1:       reach = sb.alarm_ms;
      default: reach = sb.window_ms;
    endcase
    reach = (reach > 300) ? 300 : reach + 3;
    n = ($urandom_range(3) == 0) ? $urandom_range(1, reach) : $urandom_range(1, 8);
    repeat (n) tick();
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned stop_at, pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30)      try_unlock();
      else if (pick < 45) change_code();
      else if (pick < 70) tick_burst();
      else if (pick < 80) edit_entry();
      else if (pick < 85) press(KEY_CLEAR);
      else                offer(1'($urandom_range(1)), KEY_W'($urandom_range(15)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.mode  = MODE_TICK;
    in_ch.key   = '0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_RELOCK;
    cfg_data    = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings, stored code 1,2,3,4
    offer(MODE_TICK, KEY_CLEAR);          // key ignored on a tick
    press(4'd5);                          // digit in time view: ignored
    press(KEY_VIEW_FIRST + 4'd1);
    press(KEY_ENTER);
    press(4'd9);
    press(KEY_ENTER);                     // too few digits
    press(KEY_CLEAR);                     // backspace to empty
    press(KEY_CHANGE);                    // empty entry view -> change view
    press(4'd3);
    press(KEY_CHANGE);                    // too few digits
    press(KEY_VIEW_FIRST);
    press(KEY_ENTER);
    press(4'd1);
    press(4'd2);
    press(4'd3);
    press(4'd4);
    press(4'd0);                          // past the code length: ignored
    press(KEY_ENTER);                     // opens
    press(KEY_VIEW_LAST);
    press(KEY_ENTER);
    repeat (CODE_DIGITS) press(4'd8);
    press(KEY_ENTER);                     // wrong code while open
    press(KEY_CLEAR);                     // nothing to remove: close

    // Zero delays and window, highest try limit
    settle();
    write_settings(16'd0, 16'd0, 16'd0, {13'($urandom()), 3'd7});
    run_random(200);

    // Largest delays, try limit of one; open and tick well short of the delays
    settle();
    write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, {13'($urandom()), 3'd1});
    no_gaps = 1'b1;
    leave_entry();
    press(KEY_ENTER);
    for (int i = 0; i < CODE_DIGITS; i++) press(KEY_W'(sb.st.code[i]));
    press(KEY_ENTER);
    repeat (40) tick();
    no_gaps = 1'b0;
    run_random(150);

    // Random small settings
    for (int p = 0; p < 4; p++) begin
      settle();
      write_settings(CFG_W'($urandom_range(0, 60)), CFG_W'($urandom_range(0, 150)),
                     CFG_W'($urandom_range(0, 200)),
                     {13'($urandom()), 3'($urandom_range(2, 7))});
      no_gaps = (p == 1);
      run_random(200);
    end

    // Try limit of zero: the first failure locks out, everything after is ignored
    settle();
    write_settings(CFG_W'($urandom_range(0, 60)), CFG_W'($urandom_range(0, 150)),
                   CFG_W'($urandom_range(0, 200)), 16'h0008);
    guard_on = 1'b0;
    leave_entry();
    press(KEY_ENTER);
    press(KEY_W'((sb.st.code[0] + 1) % 10));
    for (int i = 1; i < CODE_DIGITS; i++) press(KEY_W'(sb.st.code[i]));
    press(KEY_ENTER);
    repeat (30) offer(1'($urandom_range(1)), KEY_W'($urandom_range(15)));

    // Drain and report
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d status transactions never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random back-pressure, one long hold-off, result check
  // --------------------------------------------------------------------------
  initial begin : drain
    int unsigned stall_left, quiet_left, roll;
    bit          held_off, rdy;
    status_t     got;
    stall_left = 0;
    quiet_left = 0;
    held_off   = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.lamps      = out_ch.lamps;
        got.door_open  = out_ch.door_open;
        got.lock_state = out_ch.lock_state;
        got.event_res  = out_ch.event_res;
        got.view       = out_ch.view;
        got.entered    = out_ch.entered;
        sb.check_status(got);
        results_seen++;
      end
      // long hold-off so the block backs up into its input
      if (!held_off && results_seen >= HOLD_AT) begin
        held_off   = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (quiet_left != 0) begin
        quiet_left--;
        rdy = 1'b1;
      end else begin
        roll = $urandom_range(99);
        rdy  = 1'b1;
        if (roll < 2) begin
          quiet_left = $urandom_range(100, 300);
        end else if (roll >= 70) begin
          rdy = 1'b0;
          if (roll < 90)      stall_left = $urandom_range(0, 2);
          else if (roll < 98) stall_left = $urandom_range(3, 10);
          else                stall_left = $urandom_range(20, 50);
        end
      end
      out_ch.ready <= rst ? 1'b0 : rdy;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either side
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no transaction for %0d cycles", $time, idle);
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
design/ckl_pkg.sv
design/ckl_if.sv
design/ckl_cfg_regs.sv
design/ckl_step.sv
design/keypad_code_lock_controller.sv
sim/tb_top.sv
